### rtl/rwm_pkg.sv
// rwm_pkg: shared types and constants of the raster weight map query block
// used by rwm_ctrl, rwm_datapath and raster_weight_map_query; no dependencies
package rwm_pkg;

    localparam int MAX_CELLS_DEF = 4096;
    localparam int MAX_SIDE_DEF  = 64;

    localparam int POS_W      = 32;
    localparam int SHIFT_W    = 5;
    localparam int WEIGHT_W   = 2;
    localparam int SIDE_CFG_W = 7;
    localparam int OP_W       = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SHIFT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS       = 3'd4;

    localparam logic [WEIGHT_W-1:0] W_EMPTY  = 2'd0;
    localparam logic [WEIGHT_W-1:0] W_WEAK   = 2'd1;
    localparam logic [WEIGHT_W-1:0] W_STRONG = 2'd2;
    localparam logic [WEIGHT_W-1:0] W_FULL   = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_SET   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_WIPE,
        ST_SET_ADDR,
        ST_SET_READ,
        ST_SET_WRITE,
        ST_ALIGN,
        ST_WINDOW,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } rwm_state_t;

    typedef struct packed {
        logic load_in;
        logic sweep_en;
        logic set_addr;
        logic set_write;
        logic align;
        logic window;
        logic scan_step;
        logic out_load;
    } rwm_cmd_t;

    typedef struct packed {
        op_t  op;
        logic bad;
        logic sweep_last;
        logic win_ok;
        logic scan_last;
        logic pipe_empty;
        logic out_free;
    } rwm_status_t;

endpackage

### rtl/raster_weight_map_query.sv
// raster_weight_map_query: top level, joins rwm_ctrl and rwm_datapath
// depends on rwm_pkg, rwm_ctrl, rwm_datapath
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid / s_tready  s_tuser operation, s_tdata pos/weight/shift
//  m_       out  m_tvalid / m_tready  m_tdata weight_out, m_tuser bad_scale
//  cfg_     in   cfg_wr_en            cfg_addr, cfg_wr_data
//
// one word at a time; set passes SET_ADDR, SET_READ, SET_WRITE; clear sweeps all
// cells; no-op or bad-scale query goes to DONE; others scan the clipped window,
// one memory read per cycle; after reset a sweep clears memory, s_tready stays low
// the output register holds a result while m_tready is low; the next word is
// still taken and waits at its last step
module raster_weight_map_query import rwm_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // pos_x, pos_y, weight_in, query_shift
    input  logic [OP_W-1:0]       s_tuser,   // operation
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // weight_out
    output logic                  m_tuser    // bad_scale
);

    rwm_cmd_t    cmd;
    rwm_status_t status;

    rwm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rwm_datapath #(
        .MAX_CELLS (MAX_CELLS),
        .MAX_SIDE  (MAX_SIDE)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cmd.sweep_en)
        else $error("input taken during memory sweep");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken before first finished");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten while stalled");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_write |-> !cmd.sweep_en)
        else $error("set write collides with sweep");
`endif

endmodule

### rtl/rwm_ctrl.sv
// rwm_ctrl: sequencing state machine of the raster weight map query block
// depends on rwm_pkg; drives rwm_datapath through rwm_cmd_t
module rwm_ctrl import rwm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output rwm_cmd_t    cmd,
    input  rwm_status_t status
);

    rwm_state_t state_reg;
    rwm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.sweep_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                unique case (status.op)
                    OP_CLEAR: state_next = ST_WIPE;
                    OP_SET:   state_next = ST_SET_ADDR;
                    OP_QUERY: state_next = status.bad ? ST_DONE : ST_ALIGN;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_WIPE: begin
                if (status.sweep_last) state_next = ST_DONE;
            end
            ST_SET_ADDR:  state_next = ST_SET_READ;
            ST_SET_READ:  state_next = ST_SET_WRITE;
            ST_SET_WRITE: state_next = ST_DONE;
            ST_ALIGN:     state_next = ST_WINDOW;
            ST_WINDOW:    state_next = ST_SCAN;
            ST_SCAN: begin
                if (!status.win_ok || status.scan_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (status.pipe_empty) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_INIT:      cmd.sweep_en = 1'b1;
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_WIPE:      cmd.sweep_en = 1'b1;
            ST_SET_ADDR:  cmd.set_addr = 1'b1;
            ST_SET_WRITE: cmd.set_write = 1'b1;
            ST_ALIGN:     cmd.align = 1'b1;
            ST_WINDOW:    cmd.window = 1'b1;
            ST_SCAN:      cmd.scan_step = status.win_ok;
            ST_DONE:      cmd.out_load = status.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/rwm_datapath.sv
// rwm_datapath: config registers, cell memory, window scan and result register
// depends on rwm_pkg; commanded by rwm_ctrl
module rwm_datapath import rwm_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF,
    parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  rwm_cmd_t              cmd,
    output rwm_status_t           status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int IDX_W  = 2 * SIDE_W;
    localparam int AW     = $clog2(MAX_CELLS);
    localparam int SUM_W  = IDX_W + 1;

    // configuration
    logic [POS_W-1:0]   origin_x_reg;
    logic [POS_W-1:0]   origin_y_reg;
    logic [SHIFT_W-1:0] cell_shift_reg;
    logic [SIDE_W-1:0]  columns_reg;
    logic [SIDE_W-1:0]  rows_reg;
    logic [SIDE_W-1:0]  side_sat;

    // captured word
    op_t                 op_reg;
    logic [POS_W-1:0]    px_reg;
    logic [POS_W-1:0]    py_reg;
    logic [WEIGHT_W-1:0] win_reg;
    logic [SHIFT_W-1:0]  qs_reg;

    // alignment and window
    logic [POS_W-1:0]        mask;
    logic [POS_W-1:0]        dx;
    logic [POS_W-1:0]        dy;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic [SHIFT_W-1:0]      k_reg;
    logic [2*SIDE_W:0]       clip_x;
    logic [2*SIDE_W:0]       clip_y;
    logic [SIDE_W-1:0]       sy_reg;
    logic [SIDE_W-1:0]       ex_reg;
    logic [SIDE_W-1:0]       ey_reg;
    logic                    win_ok_reg;

    // scan
    logic [SIDE_W-1:0]   i_reg;
    logic [SIDE_W-1:0]   j_reg;
    logic                i_end;
    logic                j_end;
    logic [SIDE_W-1:0]   mul_a;
    logic [SIDE_W-1:0]   mul_b;
    logic [IDX_W-1:0]    idx_next;
    logic [IDX_W-1:0]    idx_reg;
    logic                idx_in_range;
    logic                set_ok_reg;
    logic                p1_valid_reg;
    logic                p2_valid_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic                weak_reg;
    logic [WEIGHT_W-1:0] cell_w_reg;

    // memory
    logic [WEIGHT_W-1:0] mem [MAX_CELLS];
    logic [WEIGHT_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WEIGHT_W-1:0] mem_wdata;
    logic [AW-1:0]       sweep_cnt_reg;
    logic                sweep_last;

    // result
    logic                bad;
    logic [63:0]         f2;
    logic [63:0]         sum64;
    logic [WEIGHT_W-1:0] cls;
    logic                m_tvalid_reg;
    logic [WEIGHT_W-1:0] weight_out_reg;
    logic                bad_reg;

    // clip [p, p + 2^k) to [0, lim); returns {nonempty, start, end}
    function automatic logic [2*SIDE_W:0] clip(input logic signed [POS_W-1:0] p,
                                                input logic [SHIFT_W-1:0] k,
                                                input logic [SIDE_W-1:0] lim);
        logic [33:0]        factor;
        logic signed [33:0] p_ext;
        logic signed [33:0] pe;
        logic signed [33:0] lim34;
        logic signed [33:0] s34;
        logic signed [33:0] e34;
        factor = 34'd1 << k;
        p_ext  = {{2{p[POS_W-1]}}, p};
        pe     = p_ext + $signed(factor);
        lim34  = $signed(34'(lim));
        s34    = p_ext[33] ? 34'sd0 : p_ext;
        e34    = (pe > lim34) ? lim34 : pe;
        return {(s34 < e34), s34[SIDE_W-1:0], e34[SIDE_W-1:0]};
    endfunction

    assign side_sat = (32'(cfg_wr_data[SIDE_CFG_W-1:0]) > 32'(MAX_SIDE))
                      ? SIDE_W'(MAX_SIDE) : SIDE_W'(cfg_wr_data[SIDE_CFG_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cell_shift_reg <= '0;
            columns_reg    <= SIDE_W'(MAX_SIDE);
            rows_reg       <= SIDE_W'(MAX_SIDE);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ORIGIN_X:   origin_x_reg <= cfg_wr_data;
                REG_ORIGIN_Y:   origin_y_reg <= cfg_wr_data;
                REG_CELL_SHIFT: cell_shift_reg <= cfg_wr_data[SHIFT_W-1:0];
                REG_COLUMNS:    columns_reg <= side_sat;
                REG_ROWS:       rows_reg <= side_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= op_t'(s_tuser);
            px_reg  <= s_tdata[31:0];
            py_reg  <= s_tdata[63:32];
            win_reg <= s_tdata[65:64];
            qs_reg  <= s_tdata[70:66];
        end
    end

    // snap both points to the cell grid, difference is an exact multiple of the cell
    assign mask = {POS_W{1'b1}} << cell_shift_reg;
    assign dx   = (px_reg & mask) - (origin_x_reg & mask);
    assign dy   = (py_reg & mask) - (origin_y_reg & mask);

    always_ff @(posedge aclk) begin
        if (cmd.align) begin
            x_reg <= $signed(dx) >>> cell_shift_reg;
            y_reg <= $signed(dy) >>> cell_shift_reg;
            k_reg <= qs_reg - cell_shift_reg;
        end
    end

    assign clip_x = clip(x_reg, k_reg, columns_reg);
    assign clip_y = clip(y_reg, k_reg, rows_reg);

    assign j_end = (SIDE_W'(j_reg + 1'b1) == ey_reg);
    assign i_end = (SIDE_W'(i_reg + 1'b1) == ex_reg);

    assign mul_a    = cmd.set_addr ? px_reg[SIDE_W-1:0] : i_reg;
    assign mul_b    = cmd.set_addr ? py_reg[SIDE_W-1:0] : j_reg;
    assign idx_next = IDX_W'(IDX_W'(mul_a) * IDX_W'(rows_reg)) + IDX_W'(mul_b);
    assign idx_in_range = (32'(idx_reg) < 32'(MAX_CELLS));

    always_ff @(posedge aclk) begin
        if (cmd.window) begin
            i_reg      <= clip_x[2*SIDE_W-1:SIDE_W];
            ex_reg     <= clip_x[SIDE_W-1:0];
            j_reg      <= clip_y[2*SIDE_W-1:SIDE_W];
            sy_reg     <= clip_y[2*SIDE_W-1:SIDE_W];
            ey_reg     <= clip_y[SIDE_W-1:0];
            win_ok_reg <= clip_x[2*SIDE_W] && clip_y[2*SIDE_W];
        end else if (cmd.scan_step) begin
            if (j_end) begin
                j_reg <= sy_reg;
                i_reg <= SIDE_W'(i_reg + 1'b1);
            end else begin
                j_reg <= SIDE_W'(j_reg + 1'b1);
            end
        end
        if (cmd.set_addr || cmd.scan_step) begin
            idx_reg <= idx_next;
        end
        if (cmd.set_addr) begin
            set_ok_reg <= (win_reg != W_EMPTY) && (px_reg < 32'(columns_reg))
                          && (py_reg < 32'(rows_reg))
                          && (32'(idx_next) < 32'(MAX_CELLS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            sweep_cnt_reg <= '0;
        end else begin
            p1_valid_reg <= cmd.scan_step;
            p2_valid_reg <= p1_valid_reg && idx_in_range;
            if (cmd.sweep_en) begin
                sweep_cnt_reg <= sweep_last ? '0 : AW'(sweep_cnt_reg + 1'b1);
            end
        end
    end

    assign sweep_last = (sweep_cnt_reg == AW'(MAX_CELLS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.window) begin
            sum_reg    <= '0;
            weak_reg   <= 1'b0;
            cell_w_reg <= W_EMPTY;
        end else if (p2_valid_reg) begin
            cell_w_reg <= rd_data_reg;
            unique case (rd_data_reg)
                W_FULL:   sum_reg <= SUM_W'(sum_reg + 2'd2);
                W_STRONG: sum_reg <= SUM_W'(sum_reg + 1'b1);
                W_WEAK:   weak_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    assign mem_we    = cmd.sweep_en || (cmd.set_write && set_ok_reg);
    assign mem_waddr = cmd.sweep_en ? sweep_cnt_reg : AW'(idx_reg);
    assign mem_wdata = cmd.sweep_en ? W_EMPTY : (rd_data_reg | win_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[AW'(idx_reg)];
    end

    assign bad   = (qs_reg < cell_shift_reg);
    assign f2    = 64'd1 << {k_reg, 1'b0};
    assign sum64 = 64'(sum_reg);

    always_comb begin
        priority if (k_reg == '0) begin
            cls = cell_w_reg;
        end else if (sum64 == (f2 << 1)) begin
            cls = W_FULL;
        end else if (sum64 > f2) begin
            cls = W_STRONG;
        end else if (sum64 < f2) begin
            cls = (weak_reg || sum_reg != '0) ? W_WEAK : W_EMPTY;
        end else begin
            cls = weak_reg ? W_STRONG : W_WEAK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            weight_out_reg <= (op_reg == OP_QUERY && !bad) ? cls : W_EMPTY;
            bad_reg        <= (op_reg == OP_QUERY) && bad;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(weight_out_reg);
    assign m_tuser  = bad_reg;

    assign status.op         = op_reg;
    assign status.bad        = bad;
    assign status.sweep_last = sweep_last;
    assign status.win_ok     = win_ok_reg;
    assign status.scan_last  = i_end && j_end;
    assign status.pipe_empty = !p1_valid_reg && !p2_valid_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule

### verif/tb_raster_weight_map_query.sv
// tb_raster_weight_map_query: self-checking testbench for the raster weight map query block
// keeps its own copy of the cell map and registers and predicts every result word
// depends on rwm_pkg and raster_weight_map_query
module tb_raster_weight_map_query;
    import rwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic                bad;
    } answer_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [OP_W-1:0]       s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    logic [WEIGHT_W-1:0] map_cells [MAX_CELLS_DEF];
    logic [31:0]         org_x   = '0;
    logic [31:0]         org_y   = '0;
    logic [4:0]          cell_sh = '0;
    int                  n_cols  = MAX_SIDE_DEF;
    int                  n_rows  = MAX_SIDE_DEF;

    answer_t pending_answers[$];
    int      errors         = 0;
    int      send_idle_pct  = 26;
    int      recv_stall_pct = 74;

    raster_weight_map_query dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),   // pos_x, pos_y, weight_in, query_shift
        .s_tuser     (s_tuser),   // operation
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),   // weight_out
        .m_tuser     (m_tuser)    // bad_scale
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [WEIGHT_W-1:0] stored_weight(longint cx, longint cy);
        longint idx;
        if (cx < 0 || cy < 0 || cx >= n_cols || cy >= n_rows) return W_EMPTY;
        idx = cx * n_rows + cy;
        if (idx >= MAX_CELLS_DEF) return W_EMPTY;
        return map_cells[idx];
    endfunction

    function automatic longint grid_coord(logic [31:0] pos, logic [31:0] org);
        logic [31:0] mask;
        logic [31:0] diff;
        mask = 32'hFFFF_FFFF << cell_sh;
        diff = (pos & mask) - (org & mask);
        return longint'($signed(diff)) / (longint'(1) << cell_sh);
    endfunction

    function automatic logic [WEIGHT_W-1:0] block_weight(logic [31:0] px, logic [31:0] py,
                                                         logic [4:0] qs);
        longint cx, cy, span, x0, y0, x1, y1, i, j;
        longint unsigned total, area;
        logic [WEIGHT_W-1:0] w;
        bit any_weak;
        cx = grid_coord(px, org_x);
        cy = grid_coord(py, org_y);
        if (qs == cell_sh) return stored_weight(cx, cy);
        span = longint'(1) << (qs - cell_sh);
        x0 = (cx < 0) ? 0 : cx;
        y0 = (cy < 0) ? 0 : cy;
        x1 = (cx + span > n_cols) ? n_cols : cx + span;
        y1 = (cy + span > n_rows) ? n_rows : cy + span;
        total = 0;
        any_weak = 1'b0;
        for (i = x0; i < x1; i++) begin
            for (j = y0; j < y1; j++) begin
                w = stored_weight(i, j);
                if (w == W_FULL) total += 2;
                else if (w == W_STRONG) total += 1;
                else if (w == W_WEAK) any_weak = 1'b1;
            end
        end
        area = longint'(span) * longint'(span);
        if (total == 2 * area) return W_FULL;
        if (total > area) return W_STRONG;
        if (total < area) return (any_weak || total > 0) ? W_WEAK : W_EMPTY;
        return any_weak ? W_STRONG : W_WEAK;
    endfunction

    task automatic predict_answer(op_t op, logic [31:0] px, logic [31:0] py,
                                  logic [WEIGHT_W-1:0] w, logic [4:0] qs);
        answer_t a;
        longint  idx;
        a.weight = W_EMPTY;
        a.bad    = 1'b0;
        case (op)
            OP_CLEAR: begin
                foreach (map_cells[k]) map_cells[k] = W_EMPTY;
            end
            OP_SET: begin
                if (w != W_EMPTY && px < n_cols && py < n_rows) begin
                    idx = longint'(px) * n_rows + longint'(py);
                    if (idx < MAX_CELLS_DEF) map_cells[idx] = map_cells[idx] | w;
                end
            end
            OP_QUERY: begin
                if (qs < cell_sh) a.bad = 1'b1;
                else a.weight = block_weight(px, py, qs);
            end
            default: ;
        endcase
        pending_answers.push_back(a);
    endtask

    always @(posedge aclk) begin : check_answers
        answer_t due;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected word: weight_out %0d bad_scale %0d", m_tdata, m_tuser);
                errors++;
            end else begin
                due = pending_answers.pop_front();
                if (m_tdata !== M_TDATA_W'(due.weight)) begin
                    $error("weight_out: expected %0d, actual %0d", due.weight, m_tdata);
                    errors++;
                end
                if (m_tuser !== due.bad) begin
                    $error("bad_scale: expected %0d, actual %0d", due.bad, m_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic send_word(op_t op, logic [31:0] px, logic [31:0] py,
                             logic [WEIGHT_W-1:0] w, logic [4:0] qs);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, qs, w, py, px};
        do @(posedge aclk); while (!s_tready);
        predict_answer(op, px, py, w, qs);
    endtask

    task automatic wait_for_answers();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_ORIGIN_X:   org_x = val;
            REG_ORIGIN_Y:   org_y = val;
            REG_CELL_SHIFT: cell_sh = val[4:0];
            REG_COLUMNS:    n_cols = (val[6:0] > MAX_SIDE_DEF) ? MAX_SIDE_DEF : val[6:0];
            REG_ROWS:       n_rows = (val[6:0] > MAX_SIDE_DEF) ? MAX_SIDE_DEF : val[6:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic test_point_ops();
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd0);
        send_word(OP_SET, 32'd0, 32'd0, W_FULL, 5'd0);
        send_word(OP_SET, 32'd63, 32'd63, W_WEAK, 5'd0);
        send_word(OP_SET, 32'd1, 32'd0, W_STRONG, 5'd0);
        send_word(OP_SET, 32'd1, 32'd0, W_WEAK, 5'd0);
        send_word(OP_SET, 32'd2, 32'd2, W_EMPTY, 5'd0);
        send_word(OP_SET, 32'd64, 32'd0, W_FULL, 5'd0);
        send_word(OP_SET, 32'd0, 32'hFFFF_FFFF, W_FULL, 5'd0);
        send_word(OP_QUERY, 32'd1, 32'd0, W_EMPTY, 5'd0);
        send_word(OP_QUERY, 32'd63, 32'd63, W_EMPTY, 5'd0);
        send_word(OP_QUERY, 32'd64, 32'd0, W_EMPTY, 5'd0);
        send_word(OP_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, W_EMPTY, 5'd0);
        send_word(OP_NOP, $urandom, $urandom, 2'($urandom), 5'($urandom));
    endtask

    task automatic test_coarse_blocks();
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd1);
        send_word(OP_SET, 32'd0, 32'd1, W_WEAK, 5'd0);
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd1);
        send_word(OP_SET, 32'd1, 32'd1, W_FULL, 5'd0);
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd1);
        send_word(OP_SET, 32'd0, 32'd1, W_FULL, 5'd0);
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd1);
        send_word(OP_QUERY, 32'd62, 32'd62, W_EMPTY, 5'd1);
        send_word(OP_QUERY, 32'd4, 32'd4, W_EMPTY, 5'd1);
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd2);
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd31);
    endtask

    task automatic test_register_extremes();
        wait_for_answers();
        write_reg(REG_ORIGIN_X, 32'h8000_0000);
        write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
        write_reg(REG_CELL_SHIFT, 32'd31);
        write_reg(REG_COLUMNS, 32'd127);
        write_reg(REG_ROWS, 32'd1);
        write_reg(REG_SPARE, $urandom);
        send_word(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, W_EMPTY, 5'd31);
        send_word(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, W_EMPTY, 5'd30);
        wait_for_answers();
        write_reg(REG_COLUMNS, 32'd0);
        send_word(OP_SET, 32'd0, 32'd0, W_FULL, 5'd0);
        send_word(OP_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, W_EMPTY, 5'd31);
        send_word(OP_CLEAR, $urandom, $urandom, 2'($urandom), 5'($urandom));
        wait_for_answers();
        write_reg(REG_ORIGIN_X, 32'd0);
        write_reg(REG_ORIGIN_Y, 32'd0);
        write_reg(REG_CELL_SHIFT, 32'd0);
        write_reg(REG_COLUMNS, 32'd64);
        write_reg(REG_ROWS, 32'd64);
        send_word(OP_QUERY, 32'd0, 32'd0, W_EMPTY, 5'd0);
    endtask

    task automatic test_random_traffic(int words, int idle_pct, int stall_pct);
        int          pick, cx, cy, qsel;
        logic [31:0] px, py, low_mask;
        logic [4:0]  qs;
        wait_for_answers();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(REG_ORIGIN_X, $urandom);
        write_reg(REG_ORIGIN_Y, $urandom);
        write_reg(REG_CELL_SHIFT, $urandom_range(0, 9));
        write_reg(REG_COLUMNS, ($urandom_range(99) < 80) ? $urandom_range(1, 12)
                                                         : $urandom_range(0, 127));
        write_reg(REG_ROWS, ($urandom_range(99) < 80) ? $urandom_range(1, 12)
                                                      : $urandom_range(0, 127));
        low_mask = ~(32'hFFFF_FFFF << cell_sh);
        repeat (words) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                send_word(OP_CLEAR, $urandom, $urandom, 2'($urandom), 5'($urandom));
            end else if (pick < 8) begin
                send_word(OP_NOP, $urandom, $urandom, 2'($urandom), 5'($urandom));
            end else if (pick < 45) begin
                px = ($urandom_range(99) < 85) ? $urandom_range(0, n_cols) : $urandom;
                py = ($urandom_range(99) < 85) ? $urandom_range(0, n_rows) : $urandom;
                send_word(OP_SET, px, py, 2'($urandom), 5'($urandom));
            end else begin
                cx = int'($urandom_range(0, n_cols + 3)) - 2;
                cy = int'($urandom_range(0, n_rows + 3)) - 2;
                px = org_x + (32'(cx) << cell_sh) + ($urandom & low_mask);
                py = org_y + (32'(cy) << cell_sh) + ($urandom & low_mask);
                if ($urandom_range(99) < 10) px = $urandom;
                if ($urandom_range(99) < 10) py = $urandom;
                qsel = $urandom_range(99);
                if (qsel < 60) begin
                    qsel = cell_sh + $urandom_range(0, 3);
                    qs = (qsel > 31) ? 5'd31 : 5'(qsel);
                end else if (qsel < 80 || cell_sh == 0) begin
                    qs = 5'($urandom);
                end else begin
                    qs = cell_sh - 5'd1;
                end
                send_word(OP_QUERY, px, py, 2'($urandom), qs);
            end
        end
    endtask

    initial begin
        foreach (map_cells[k]) map_cells[k] = W_EMPTY;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        test_point_ops();
        test_coarse_blocks();
        test_register_extremes();
        test_random_traffic(37, 26, 74);
        test_random_traffic(37, 74, 26);
        test_random_traffic(37, 0, 0);
        wait_for_answers();
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
